// File: hdl/tmss_pkg.sv
// Shared types, codes and step tables for the timed motor step sequencer.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`default_nettype none

package tmss_pkg;

  localparam int unsigned TIMER_WIDTH_DEF     = 10;
  localparam int unsigned MAX_TABLE_STEPS_DEF = 16;

  localparam int unsigned MS_W      = 10;  // widest step duration is 900 ms
  localparam int unsigned LEN_W     = 4;   // longest table holds 13 steps
  localparam int unsigned TBL_IDX_W = 8;   // table lookup index, wider than any step count

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_DRIVE = 2'd2,
    FUNC_EYES  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    SEQ_NONE  = 2'd0,
    SEQ_DANCE = 2'd1,
    SEQ_SCAN  = 2'd2,
    SEQ_PRANK = 2'd3
  } seq_e;

  // Table selector; move_kind uses the same codes, KIND_NONE starts nothing
  localparam logic [1:0] TBL_DANCE = 2'd0;
  localparam logic [1:0] TBL_SCAN  = 2'd1;
  localparam logic [1:0] TBL_PRANK = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Step actions; the motor ones share their codes with the drive direction
  typedef enum logic [2:0] {
    ACT_STOP     = 3'd0,
    ACT_FWD      = 3'd1,
    ACT_BACK     = 3'd2,
    ACT_LEFT     = 3'd3,
    ACT_RIGHT    = 3'd4,
    ACT_EYES_ON  = 3'd5,
    ACT_EYES_OFF = 3'd6
  } act_e;

  localparam logic [3:0] PAT_STOP  = 4'h0;
  localparam logic [3:0] PAT_FWD   = 4'hA;
  localparam logic [3:0] PAT_BACK  = 4'h5;
  localparam logic [3:0] PAT_LEFT  = 4'h9;
  localparam logic [3:0] PAT_RIGHT = 4'h6;

  typedef struct packed {
    act_e             act;
    logic [MS_W-1:0]  ms;
  } step_t;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] move_kind;
    logic [2:0] direction;
    logic       eyes_value;
  } item_t;

  typedef struct packed {
    logic        move_done;
    logic        move_started;
    logic [3:0]  step_number;
    logic [1:0]  running_move;
    logic        eyes_on;
    logic [3:0]  motor_pins;
  } res_t;

  // Lookups the core needs from the step tables
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [MS_W-1:0]  cur_ms;
    act_e             nxt_act;
    act_e             start_act;
  } tbl_rd_t;

  function automatic logic [3:0] dir_pattern(input logic [2:0] code);
    logic [3:0] p;
    case (code)
      ACT_FWD:   p = PAT_FWD;
      ACT_BACK:  p = PAT_BACK;
      ACT_LEFT:  p = PAT_LEFT;
      ACT_RIGHT: p = PAT_RIGHT;
      default:   p = PAT_STOP;
    endcase
    return p;
  endfunction

  function automatic logic [LEN_W-1:0] tbl_len(input logic [1:0] tbl);
    logic [LEN_W-1:0] n;
    case (tbl)
      TBL_DANCE: n = LEN_W'(13);
      TBL_SCAN:  n = LEN_W'(9);
      TBL_PRANK: n = LEN_W'(7);
      default:   n = '0;
    endcase
    return n;
  endfunction

  // Entries past a table's end read as stop with zero duration
  function automatic step_t tbl_entry(input logic [1:0] tbl, input logic [TBL_IDX_W-1:0] idx);
    step_t e;
    e = '{act: ACT_STOP, ms: '0};
    case (tbl)
      TBL_DANCE: begin
        case (idx)
          8'd0:    e = '{act: ACT_FWD,   ms: MS_W'(300)};
          8'd1:    e = '{act: ACT_LEFT,  ms: MS_W'(350)};
          8'd2:    e = '{act: ACT_FWD,   ms: MS_W'(250)};
          8'd3:    e = '{act: ACT_RIGHT, ms: MS_W'(350)};
          8'd4:    e = '{act: ACT_BACK,  ms: MS_W'(300)};
          8'd5:    e = '{act: ACT_RIGHT, ms: MS_W'(400)};
          8'd6:    e = '{act: ACT_FWD,   ms: MS_W'(200)};
          8'd7:    e = '{act: ACT_LEFT,  ms: MS_W'(500)};
          8'd8:    e = '{act: ACT_BACK,  ms: MS_W'(250)};
          8'd9:    e = '{act: ACT_RIGHT, ms: MS_W'(500)};
          8'd10:   e = '{act: ACT_FWD,   ms: MS_W'(300)};
          8'd11:   e = '{act: ACT_LEFT,  ms: MS_W'(300)};
          default: e = '{act: ACT_STOP,  ms: '0};
        endcase
      end
      TBL_SCAN: begin
        case (idx)
          8'd0:    e = '{act: ACT_LEFT, ms: MS_W'(400)};
          8'd1:    e = '{act: ACT_STOP, ms: MS_W'(800)};
          8'd2:    e = '{act: ACT_LEFT, ms: MS_W'(400)};
          8'd3:    e = '{act: ACT_STOP, ms: MS_W'(800)};
          8'd4:    e = '{act: ACT_LEFT, ms: MS_W'(400)};
          8'd5:    e = '{act: ACT_STOP, ms: MS_W'(800)};
          8'd6:    e = '{act: ACT_LEFT, ms: MS_W'(400)};
          8'd7:    e = '{act: ACT_STOP, ms: MS_W'(500)};
          default: e = '{act: ACT_STOP, ms: '0};
        endcase
      end
      TBL_PRANK: begin
        case (idx)
          8'd0:    e = '{act: ACT_EYES_ON,  ms: MS_W'(100)};
          8'd1:    e = '{act: ACT_FWD,      ms: MS_W'(900)};
          8'd2:    e = '{act: ACT_STOP,     ms: MS_W'(150)};
          8'd3:    e = '{act: ACT_BACK,     ms: MS_W'(150)};
          8'd4:    e = '{act: ACT_STOP,     ms: MS_W'(600)};
          8'd5:    e = '{act: ACT_EYES_OFF, ms: MS_W'(200)};
          default: e = '{act: ACT_STOP,     ms: '0};
        endcase
      end
      default: e = '{act: ACT_STOP, ms: '0};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// File: hdl/tmss_rom.sv
// Step table lookups: current step duration, next step action, first action of a
// requested table and table length. Depends on tmss_pkg.
`default_nettype none

module tmss_rom (
  input  wire logic [1:0]                   run_tbl_i,   // table of the running sequence
  input  wire logic [tmss_pkg::TBL_IDX_W-1:0] cur_idx_i,
  input  wire logic [1:0]                   start_tbl_i, // table a start would select
  output tmss_pkg::tbl_rd_t                 rd_o
);

  tmss_pkg::step_t              cur_entry;
  tmss_pkg::step_t              nxt_entry;
  tmss_pkg::step_t              start_entry;
  logic [tmss_pkg::TBL_IDX_W-1:0] nxt_idx;

  assign nxt_idx     = cur_idx_i + tmss_pkg::TBL_IDX_W'(1);
  assign cur_entry   = tmss_pkg::tbl_entry(run_tbl_i, cur_idx_i);
  assign nxt_entry   = tmss_pkg::tbl_entry(run_tbl_i, nxt_idx);
  assign start_entry = tmss_pkg::tbl_entry(start_tbl_i, '0);

  assign rd_o.len       = tmss_pkg::tbl_len(run_tbl_i);
  assign rd_o.cur_ms    = cur_entry.ms;
  assign rd_o.nxt_act   = nxt_entry.act;
  assign rd_o.start_act = start_entry.act;

endmodule

`default_nettype wire

// File: hdl/tmss_core.sv
// Sequencer state and its update for one item; builds the result.
// Depends on tmss_pkg and tmss_rom.
`default_nettype none

module tmss_core #(
  parameter int unsigned TIMER_WIDTH     = tmss_pkg::TIMER_WIDTH_DEF,
  parameter int unsigned MAX_TABLE_STEPS = tmss_pkg::MAX_TABLE_STEPS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,   // item in the input register is applied now
  input  tmss_pkg::item_t    item_i,
  output tmss_pkg::res_t     res_o     // result of the item, valid with fire_i
);

  localparam int unsigned STEP_W = $clog2(MAX_TABLE_STEPS);

  tmss_pkg::seq_e          seq_q, seq_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [TIMER_WIDTH-1:0]  el_q, el_d;
  logic [3:0]              mot_q, mot_d;
  logic                    eye_q, eye_d;

  tmss_pkg::tbl_rd_t       rd;
  logic [1:0]              run_tbl;
  logic [TIMER_WIDTH-1:0]  el_inc;
  logic [STEP_W:0]         nxt_step;
  logic                    running;
  logic                    step_oob, nxt_oob;
  logic                    cancel_req, adv, start_go, drive_go, eyes_go;
  logic                    apply_en;
  tmss_pkg::act_e          apply_act;
  logic                    started, done;

  assign running  = (seq_q != tmss_pkg::SEQ_NONE);
  assign run_tbl  = seq_q - 2'd1;
  assign el_inc   = (el_q == '1) ? el_q : el_q + TIMER_WIDTH'(1);
  assign nxt_step = {1'b0, step_q} + (STEP_W + 1)'(1);

  tmss_rom u_rom (
    .run_tbl_i   (run_tbl),
    .cur_idx_i   (tmss_pkg::TBL_IDX_W'(step_q)),
    .start_tbl_i (item_i.move_kind),
    .rd_o        (rd)
  );

  assign step_oob = ((STEP_W + 1)'({1'b0, step_q}) >= (STEP_W + 1)'(rd.len))
                 || ((STEP_W + 1)'({1'b0, step_q}) >= (STEP_W + 1)'(MAX_TABLE_STEPS));
  assign nxt_oob  = (nxt_step >= (STEP_W + 1)'(rd.len))
                 || (nxt_step >= (STEP_W + 1)'(MAX_TABLE_STEPS));

  // Decode what the item asks for
  always_comb begin
    cancel_req = 1'b0;
    adv        = 1'b0;
    start_go   = 1'b0;
    drive_go   = 1'b0;
    eyes_go    = 1'b0;
    case (tmss_pkg::func_e'(item_i.func))
      tmss_pkg::FUNC_TICK: begin
        if (running) begin
          if (step_oob || rd.cur_ms == '0) begin
            cancel_req = 1'b1;
          end else if (el_inc >= TIMER_WIDTH'(rd.cur_ms)) begin
            if (nxt_oob) begin
              cancel_req = 1'b1;
            end else begin
              adv = 1'b1;
            end
          end
        end
      end
      tmss_pkg::FUNC_START: begin
        cancel_req = 1'b1;
        start_go   = (item_i.move_kind != tmss_pkg::KIND_NONE);
      end
      tmss_pkg::FUNC_DRIVE: begin
        // unknown directions leave everything alone
        if (item_i.direction <= tmss_pkg::ACT_RIGHT) begin
          cancel_req = 1'b1;
          drive_go   = 1'b1;
        end
      end
      tmss_pkg::FUNC_EYES: begin
        eyes_go = 1'b1;
      end
      default: begin
        eyes_go = 1'b0;
      end
    endcase
  end

  assign apply_en  = adv | start_go;
  assign apply_act = adv ? rd.nxt_act : rd.start_act;

  // Next state: count, cancel, advance or start, then step action, drive and eye set in that order
  always_comb begin
    seq_d   = seq_q;
    step_d  = step_q;
    el_d    = el_q;
    mot_d   = mot_q;
    eye_d   = eye_q;
    started = 1'b0;
    done    = 1'b0;

    if (running && tmss_pkg::func_e'(item_i.func) == tmss_pkg::FUNC_TICK) begin
      el_d = el_inc;
    end
    if (cancel_req && running) begin
      mot_d = tmss_pkg::PAT_STOP;
      if (seq_q == tmss_pkg::SEQ_PRANK) begin
        eye_d = 1'b0;
      end
      seq_d  = tmss_pkg::SEQ_NONE;
      step_d = '0;
      el_d   = '0;
      done   = 1'b1;
    end
    if (adv) begin
      step_d = nxt_step[STEP_W-1:0];
      el_d   = '0;
    end
    if (start_go) begin
      seq_d   = tmss_pkg::seq_e'(item_i.move_kind + 2'd1);
      step_d  = '0;
      el_d    = '0;
      started = 1'b1;
    end
    if (apply_en) begin
      if (apply_act <= tmss_pkg::ACT_RIGHT) begin
        mot_d = tmss_pkg::dir_pattern(apply_act);
      end else if (apply_act == tmss_pkg::ACT_EYES_ON) begin
        eye_d = 1'b1;
      end else begin
        eye_d = 1'b0;
      end
    end
    if (drive_go) begin
      mot_d = tmss_pkg::dir_pattern(item_i.direction);
    end
    if (eyes_go) begin
      eye_d = item_i.eyes_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= tmss_pkg::SEQ_NONE;
      step_q <= '0;
      el_q   <= '0;
      mot_q  <= tmss_pkg::PAT_STOP;
      eye_q  <= 1'b0;
    end else if (fire_i) begin
      seq_q  <= seq_d;
      step_q <= step_d;
      el_q   <= el_d;
      mot_q  <= mot_d;
      eye_q  <= eye_d;
    end
  end

  assign res_o.motor_pins   = mot_d;
  assign res_o.eyes_on      = eye_d;
  assign res_o.running_move = seq_d;
  assign res_o.step_number  = (seq_d == tmss_pkg::SEQ_NONE) ? 4'd0 : step_d[3:0];
  assign res_o.move_started = started;
  assign res_o.move_done    = done;

endmodule

`default_nettype wire

// File: hdl/timed_motor_step_sequencer_top.sv
// Top level of the timed motor step sequencer: input register, update core and
// result register with stream handshakes. Depends on tmss_pkg and tmss_core.
`default_nettype none

// Plays fixed step tables (dance, scan, prank) onto four H-bridge pins and an
// eye LED. Each transfer on the slave side is one command chosen by tuser: a
// one-ms tick, a sequence start, a manual drive or an eye set; each produces
// exactly one result transfer carrying the pin pattern, eye level, running
// sequence, step index and start/done flags after the command. One command is
// taken every clock cycle while the master side applies no back-pressure; a result
// passes through the input register and then the result register before it is
// offered on the master side, and the state update plus table lookup sits in
// the single stage between them. Back-pressure on the master side stalls both
// registers but a new command is still taken whenever the input register is
// empty or the result register drains in the same cycle.

module timed_motor_step_sequencer_top #(
  parameter int unsigned TIMER_WIDTH     = tmss_pkg::TIMER_WIDTH_DEF,
  parameter int unsigned MAX_TABLE_STEPS = tmss_pkg::MAX_TABLE_STEPS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // [1:0] move_kind, [4:2] direction, [5] eyes_value, [7:6] zero
  input  wire logic [tmss_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] func
  input  wire logic [tmss_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [3:0] motor_pins, [4] eyes_on, [6:5] running_move, [10:7] step_number,
  // [11] move_started, [12] move_done, [15:13] zero
  output      logic [tmss_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  logic              in_vld_q;
  tmss_pkg::item_t   item_q;
  logic              out_vld_q;
  tmss_pkg::res_t    res_q;
  tmss_pkg::res_t    res;
  logic              adv;
  logic              fire;

  assign adv           = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && adv;
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.func       <= s_axis_tuser[1:0];
      item_q.move_kind  <= s_axis_tdata[1:0];
      item_q.direction  <= s_axis_tdata[4:2];
      item_q.eyes_value <= s_axis_tdata[5];
    end
  end

  tmss_core #(
    .TIMER_WIDTH     (TIMER_WIDTH),
    .MAX_TABLE_STEPS (MAX_TABLE_STEPS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .res_o  (res)
  );

  // Hold the result until the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, res_q};

endmodule

`default_nettype wire

// File: hdl/tmss_checker.sv
// Port-level checks for the timed motor step sequencer, bound to its top level.
// Depends on tmss_pkg and timed_motor_step_sequencer_top.
`default_nettype none

module tmss_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [tmss_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  tmss_pkg::res_t res;
  assign res = m_axis_tdata[$bits(tmss_pkg::res_t)-1:0];

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A fresh start shows a running table at its first step
  a_start_step0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.move_started |->
      res.running_move != tmss_pkg::SEQ_NONE && res.step_number == 4'd0)
    else $error("start without a running sequence at step zero");

  // Idle sequencer reports step zero
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.running_move == tmss_pkg::SEQ_NONE |-> res.step_number == 4'd0)
    else $error("step index without a running sequence");

  // An end without a restart leaves nothing running
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.move_done && !res.move_started |->
      res.running_move == tmss_pkg::SEQ_NONE)
    else $error("sequence still running after done");

  // Never drive both legs of a bridge at once
  a_pin_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      res.motor_pins == tmss_pkg::PAT_STOP || res.motor_pins == tmss_pkg::PAT_FWD ||
      res.motor_pins == tmss_pkg::PAT_BACK || res.motor_pins == tmss_pkg::PAT_LEFT ||
      res.motor_pins == tmss_pkg::PAT_RIGHT)
    else $error("illegal H-bridge pattern");

endmodule

bind timed_motor_step_sequencer_top tmss_checker u_tmss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: tb/sv/timed_motor_step_sequencer_top_test.sv
// Self-checking testbench for timed_motor_step_sequencer_top: drives commands on the
// slave stream, predicts each result transfer and compares it field by field.
// Depends on tmss_pkg and the RTL under hdl/.
`timescale 1ns / 100ps

module timed_motor_step_sequencer_top_test;
  import tmss_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned RANDOM_ITEMS = 1000;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  timed_motor_step_sequencer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Step tables, flattened: dance, then scan, then prank
  int unsigned tbl_base  [3] = '{0, 13, 22};
  int unsigned tbl_steps [3] = '{13, 9, 7};
  int unsigned step_ms   [29] = '{
    300, 350, 250, 350, 300, 400, 200, 500, 250, 500, 300, 300, 0,
    400, 800, 400, 800, 400, 800, 400, 500, 0,
    100, 900, 150, 150, 600, 200, 0};
  act_e step_act [29] = '{
    ACT_FWD, ACT_LEFT, ACT_FWD, ACT_RIGHT, ACT_BACK, ACT_RIGHT, ACT_FWD, ACT_LEFT,
    ACT_BACK, ACT_RIGHT, ACT_FWD, ACT_LEFT, ACT_STOP,
    ACT_LEFT, ACT_STOP, ACT_LEFT, ACT_STOP, ACT_LEFT, ACT_STOP, ACT_LEFT, ACT_STOP,
    ACT_STOP,
    ACT_EYES_ON, ACT_FWD, ACT_STOP, ACT_BACK, ACT_STOP, ACT_EYES_OFF, ACT_STOP};
  logic [3:0] drive_pins [5] = '{PAT_STOP, PAT_FWD, PAT_BACK, PAT_LEFT, PAT_RIGHT};

  // Predicted sequencer state
  seq_e        run_seq   = SEQ_NONE;
  logic [3:0]  run_step  = '0;
  logic [9:0]  run_ms    = '0;
  logic [3:0]  pin_state = PAT_STOP;
  logic        eye_state = 1'b0;

  res_t        pending_results [$];
  int unsigned sent_count  = 0;
  int unsigned err_count   = 0;
  int unsigned stall_count = 0;
  bit          steady      = 1'b0;

  function automatic void take_action(input act_e a);
    case (a)
      ACT_EYES_ON:  eye_state = 1'b1;
      ACT_EYES_OFF: eye_state = 1'b0;
      default:      pin_state = drive_pins[a];
    endcase
  endfunction

  function automatic bit stop_sequence();
    if (run_seq == SEQ_NONE) return 1'b0;
    pin_state = PAT_STOP;
    if (run_seq == SEQ_PRANK) eye_state = 1'b0;
    run_seq  = SEQ_NONE;
    run_step = '0;
    run_ms   = '0;
    return 1'b1;
  endfunction

  function automatic res_t apply_command(input func_e fn, input logic [1:0] kind,
                                         input logic [2:0] dir, input logic eyes);
    res_t        r;
    bit          started;
    bit          done;
    int unsigned idx;
    started = 1'b0;
    done    = 1'b0;
    case (fn)
      FUNC_TICK: begin
        if (run_seq != SEQ_NONE) begin
          idx = tbl_base[run_seq - 1] + run_step;
          if (run_ms != '1) run_ms = run_ms + 1'b1;
          if (step_ms[idx] == 0) begin
            done = stop_sequence();
          end else if (run_ms >= step_ms[idx]) begin
            if (run_step + 1 >= tbl_steps[run_seq - 1]) begin
              done = stop_sequence();
            end else begin
              run_step = run_step + 1'b1;
              run_ms   = '0;
              take_action(step_act[idx + 1]);
            end
          end
        end
      end
      FUNC_START: begin
        done = stop_sequence();
        if (kind != KIND_NONE) begin
          run_seq  = seq_e'(kind + 2'd1);
          run_step = '0;
          run_ms   = '0;
          take_action(step_act[tbl_base[kind]]);
          started = 1'b1;
        end
      end
      FUNC_DRIVE: begin
        // directions past right are dropped without cancelling
        if (dir <= ACT_RIGHT) begin
          done = stop_sequence();
          pin_state = drive_pins[dir];
        end
      end
      default: eye_state = eyes;
    endcase
    r.motor_pins   = pin_state;
    r.eyes_on      = eye_state;
    r.running_move = run_seq;
    r.step_number  = (run_seq == SEQ_NONE) ? 4'd0 : run_step;
    r.move_started = started;
    r.move_done    = done;
    return r;
  endfunction

  // Enter and leave at a falling edge; valid stays high for a following command
  task automatic send_cmd(input func_e fn, input logic [1:0] kind, input logic [2:0] dir,
                          input logic eyes);
    while (!steady && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, eyes, dir, kind};
    s_axis_tuser  <= fn;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(apply_command(fn, kind, dir, eyes));
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    send_cmd(FUNC_TICK, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
             1'($urandom_range(0, 1)));
  endtask

  task automatic send_any();
    send_cmd(func_e'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
             3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_idle_commands();
    send_cmd(FUNC_TICK, TBL_DANCE, ACT_STOP, 1'b0);
    for (int d = 0; d < 8; d++) send_cmd(FUNC_DRIVE, KIND_NONE, 3'(d), 1'b1);
    send_cmd(FUNC_EYES, TBL_PRANK, ACT_FWD, 1'b1);
    send_cmd(FUNC_EYES, TBL_SCAN, ACT_BACK, 1'b0);
    send_cmd(FUNC_START, KIND_NONE, ACT_STOP, 1'b0);
  endtask

  task automatic test_start_and_cancel();
    send_cmd(FUNC_START, TBL_DANCE, ACT_STOP, 1'b0);
    send_cmd(FUNC_TICK, TBL_DANCE, ACT_STOP, 1'b0);
    send_cmd(FUNC_START, TBL_SCAN, ACT_STOP, 1'b0);
    send_cmd(FUNC_DRIVE, TBL_SCAN, 3'd7, 1'b0);
    send_cmd(FUNC_EYES, TBL_SCAN, ACT_STOP, 1'b1);
    send_cmd(FUNC_START, KIND_NONE, ACT_STOP, 1'b0);
    send_cmd(FUNC_START, TBL_PRANK, ACT_STOP, 1'b0);
    send_cmd(FUNC_TICK, TBL_PRANK, ACT_STOP, 1'b0);
    send_cmd(FUNC_DRIVE, TBL_PRANK, ACT_STOP, 1'b0);
    send_cmd(FUNC_START, TBL_PRANK, ACT_STOP, 1'b0);
    send_cmd(FUNC_START, TBL_DANCE, ACT_STOP, 1'b0);
    send_cmd(FUNC_DRIVE, TBL_DANCE, ACT_RIGHT, 1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    int unsigned n;
    bit          paused;
    first  = sent_count;
    paused = 1'b0;
    while (sent_count - first < RANDOM_ITEMS) begin
      n = sent_count - first;
      steady = (n >= 300 && n < 500);
      if (!paused && n >= 600) begin
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) begin
        send_cmd(FUNC_START, 2'($urandom_range(TBL_DANCE, TBL_PRANK)),
                 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 150)) begin
          if ($urandom_range(0, 49) == 0) send_any();
          else send_tick();
        end
      end else begin
        send_any();
      end
    end
    steady = 1'b0;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 29);
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
      if (pending_results.size() == 0) begin
        $error("result transfer with no command outstanding: %h", m_axis_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("motor_pins", want.motor_pins, got.motor_pins);
        compare_field("eyes_on", want.eyes_on, got.eyes_on);
        compare_field("running_move", want.running_move, got.running_move);
        compare_field("step_number", want.step_number, got.step_number);
        compare_field("move_started", want.move_started, got.move_started);
        compare_field("move_done", want.move_done, got.move_done);
        compare_field("padding", 0, m_axis_tdata[OUT_DATA_W-1:$bits(res_t)]);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
  end

  initial begin
    while (stall_count < STALL_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_idle_commands();
    test_start_and_cancel();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/tmss_pkg.sv
hdl/tmss_rom.sv
hdl/tmss_core.sv
hdl/timed_motor_step_sequencer_top.sv
hdl/tmss_checker.sv
tb/sv/timed_motor_step_sequencer_top_test.sv
